// ===== hdl/token_expiry_table_defines.svh =====
// assertion macros for the token expiry table checker
// both expect clk_i and rst_ni in the scope of use
`ifndef TOKEN_EXPIRY_TABLE_DEFINES_SVH
`define TOKEN_EXPIRY_TABLE_DEFINES_SVH

// consequent must hold in the same cycle as the antecedent
`define TET_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);

// consequent must hold in the cycle after the antecedent
`define TET_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ===== hdl/tet_pkg.sv =====
// ----------------------------------------------------------------------------
// tet_pkg
// Shared types and constants of the token expiry table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package tet_pkg;

  // table size and widths
  localparam int unsigned CAPACITY_DEFAULT = 64;
  localparam int unsigned LIVE_W           = 7;
  localparam logic [LIVE_W-1:0] COUNT_MAX  = 7'd127;
  localparam int unsigned KEY_W            = 32;
  localparam int unsigned TIME_W           = 32;
  localparam int unsigned EXP_W            = TIME_W + 1;

  // queue between front and back
  localparam int unsigned QUEUE_DEPTH = 2;
  localparam int unsigned QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // register file: one register, index taken from paddr[2]
  localparam int unsigned PADDR_W      = 3;
  localparam logic        REG_LIFETIME = 1'b0;

  // command codes on the request word
  typedef enum logic [1:0] {
    CMD_GENERATE = 2'd0,
    CMD_RENEW    = 2'd1,
    CMD_COUNT    = 2'd2
  } cmd_e;

  // status codes on the response word
  typedef enum logic [1:0] {
    ST_DONE   = 2'd0,
    ST_FULL   = 2'd1,
    ST_ABSENT = 2'd2
  } status_e;

  // classified operation handed to the back end
  typedef enum logic [1:0] {
    OP_GEN,
    OP_RENEW,
    OP_COUNT,
    OP_NOP
  } op_e;

  // back end sequencer
  typedef enum logic [1:0] {
    BK_IDLE,
    BK_SCAN,
    BK_DRAIN,
    BK_DONE
  } back_state_e;

  // job queued between front and back
  typedef struct packed {
    op_e               op;
    logic [KEY_W-1:0]  key;
    logic [TIME_W-1:0] now;
    logic [EXP_W-1:0]  expiry;
  } job_t;

endpackage

`default_nettype wire

// ===== hdl/tet_if.sv =====
// ----------------------------------------------------------------------------
// tet_req_if / tet_rsp_if
// Valid/ready channels for request and response words.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

interface tet_req_if;
  logic        valid;
  logic        ready;
  logic [1:0]  command;
  logic [31:0] token_key;
  logic [31:0] now;

  modport source (output valid, command, token_key, now, input ready);
  modport sink   (input valid, command, token_key, now, output ready);
endinterface

interface tet_rsp_if;
  logic       valid;
  logic       ready;
  logic [6:0] live_count;
  logic [1:0] status;

  modport source (output valid, live_count, status, input ready);
  modport sink   (input valid, live_count, status, output ready);
endinterface

`default_nettype wire

// ===== hdl/tet_front.sv =====
// ----------------------------------------------------------------------------
// tet_front
// Accepts request words, decodes the command, computes the new expiry and
// holds the lifetime register behind the APB port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tet_front import tet_pkg::*; (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  tet_req_if.sink                 req,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready,
  output      logic               push_o,
  output      job_t               job_o,
  input  wire logic               full_i
);

  logic [TIME_W-1:0] lifetime_q, lifetime_d;
  logic              reg_wr;

  // apb register access, no wait states
  assign pready = 1'b1;
  assign reg_wr = psel && penable && pwrite && pready &&
                  (paddr[PADDR_W-1] == REG_LIFETIME);

  always_comb begin
    lifetime_d = lifetime_q;
    if (reg_wr) begin
      lifetime_d = pwdata;
    end
  end

  assign prdata = (paddr[PADDR_W-1] == REG_LIFETIME) ? lifetime_q : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lifetime_q <= '0;
    end else begin
      lifetime_q <= lifetime_d;
    end
  end

  // accept while the queue has room
  assign req.ready = !full_i;
  assign push_o    = req.valid && !full_i;

  // classify the command and build the job
  always_comb begin
    case (req.command)
      CMD_GENERATE: job_o.op = OP_GEN;
      CMD_RENEW:    job_o.op = OP_RENEW;
      CMD_COUNT:    job_o.op = OP_COUNT;
      default:      job_o.op = OP_NOP;
    endcase
    job_o.key    = req.token_key;
    job_o.now    = req.now;
    // expiry kept one bit wider so the sum never wraps
    job_o.expiry = {1'b0, req.now} + {1'b0, lifetime_q};
  end

endmodule

`default_nettype wire

// ===== hdl/tet_queue.sv =====
// ----------------------------------------------------------------------------
// tet_queue
// Short job queue between the front end and the scan engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tet_queue import tet_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  wire job_t job_i,
  output      logic full_o,
  input  wire logic pop_i,
  output      job_t job_o,
  output      logic empty_o
);

  job_t              slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_q, wr_d, rd_q, rd_d;
  logic [QCNT_W-1:0] cnt_q, cnt_d;

  assign full_o  = (cnt_q == QCNT_W'(QUEUE_DEPTH));
  assign empty_o = (cnt_q == '0);
  assign job_o   = slots[rd_q];

  // pointer and fill count update
  always_comb begin
    wr_d  = wr_q;
    rd_d  = rd_q;
    cnt_d = cnt_q;
    if (push_i) begin
      wr_d = (wr_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_q + 1'b1;
    end
    if (pop_i) begin
      rd_d = (rd_q == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_q + 1'b1;
    end
    if (push_i && !pop_i) begin
      cnt_d = cnt_q + 1'b1;
    end else if (!push_i && pop_i) begin
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q  <= '0;
      rd_q  <= '0;
      cnt_q <= '0;
    end else begin
      wr_q  <= wr_d;
      rd_q  <= rd_d;
      cnt_q <= cnt_d;
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slots[wr_q] <= job_i;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/tet_back.sv =====
// ----------------------------------------------------------------------------
// tet_back
// Scan engine: walks the slot memories one slot a cycle, finds the key,
// the first free or expired slot and the live count, then commits the
// update and loads the response register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module tet_back import tet_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire job_t job_i,
  input  wire logic empty_i,
  output      logic pop_o,
  tet_rsp_if.source rsp
);

  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;

  back_state_e       state_q, state_d;
  job_t              job_q, job_d;
  logic [IW-1:0]     scan_q, scan_d;
  logic              chk_vld_q;
  logic [IW-1:0]     chk_idx_q;
  logic              rd_used_q;
  logic [KEY_W-1:0]  rd_key_q;
  logic [EXP_W-1:0]  rd_exp_q;
  logic              hit_vld_q, hit_vld_d, hit_live_q, hit_live_d;
  logic [IW-1:0]     hit_idx_q, hit_idx_d;
  logic              room_vld_q, room_vld_d;
  logic [IW-1:0]     room_idx_q, room_idx_d;
  logic [LIVE_W-1:0] cnt_q, cnt_d;
  logic              out_valid_q, out_valid_d;
  logic [LIVE_W-1:0] out_count_q, out_count_d;
  status_e           out_status_q, out_status_d;
  logic              used_q [CAPACITY];
  logic [KEY_W-1:0]  key_mem [CAPACITY];
  logic [EXP_W-1:0]  exp_mem [CAPACITY];
  logic              key_we, exp_we;
  logic [IW-1:0]     wr_idx;
  logic              slot_live, slot_hit;

  // compare of the slot read last cycle
  assign slot_live = rd_used_q && (rd_exp_q > {1'b0, job_q.now});
  assign slot_hit  = rd_used_q && (rd_key_q == job_q.key);

  // sequencer, slot checks and commit
  always_comb begin
    state_d      = state_q;
    job_d        = job_q;
    scan_d       = scan_q;
    hit_vld_d    = hit_vld_q;
    hit_live_d   = hit_live_q;
    hit_idx_d    = hit_idx_q;
    room_vld_d   = room_vld_q;
    room_idx_d   = room_idx_q;
    cnt_d        = cnt_q;
    out_valid_d  = out_valid_q && !rsp.ready;
    out_count_d  = out_count_q;
    out_status_d = out_status_q;
    pop_o        = 1'b0;
    key_we       = 1'b0;
    exp_we       = 1'b0;
    wr_idx       = hit_idx_q;

    // first hit, first room and live count over the scan
    if (chk_vld_q) begin
      if (slot_hit && !hit_vld_q) begin
        hit_vld_d  = 1'b1;
        hit_idx_d  = chk_idx_q;
        hit_live_d = slot_live;
      end
      if (!slot_live && !room_vld_q) begin
        room_vld_d = 1'b1;
        room_idx_d = chk_idx_q;
      end
      if (slot_live && (cnt_q != COUNT_MAX)) begin
        cnt_d = cnt_q + 1'b1;
      end
    end

    case (state_q)
      BK_IDLE: begin
        if (!empty_i) begin
          pop_o      = 1'b1;
          job_d      = job_i;
          scan_d     = '0;
          hit_vld_d  = 1'b0;
          room_vld_d = 1'b0;
          cnt_d      = '0;
          state_d    = (job_i.op == OP_NOP) ? BK_DONE : BK_SCAN;
        end
      end
      BK_SCAN: begin
        if (scan_q == IW'(CAPACITY - 1)) begin
          state_d = BK_DRAIN;
        end else begin
          scan_d = scan_q + 1'b1;
        end
      end
      BK_DRAIN: begin
        state_d = BK_DONE;
      end
      BK_DONE: begin
        if (!out_valid_q || rsp.ready) begin
          out_valid_d  = 1'b1;
          out_count_d  = '0;
          out_status_d = ST_DONE;
          state_d      = BK_IDLE;
          case (job_q.op)
            OP_GEN: begin
              if (hit_vld_q) begin
                key_we = 1'b1;
                exp_we = 1'b1;
              end else if (room_vld_q) begin
                key_we = 1'b1;
                exp_we = 1'b1;
                wr_idx = room_idx_q;
              end else begin
                out_status_d = ST_FULL;
              end
            end
            OP_RENEW: begin
              if (hit_vld_q && hit_live_q) begin
                exp_we = 1'b1;
              end else begin
                out_status_d = ST_ABSENT;
              end
            end
            OP_COUNT: out_count_d = cnt_q;
            default:  out_count_d = '0;
          endcase
        end
      end
      default: state_d = BK_IDLE;
    endcase
  end

  // control registers and slot valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= BK_IDLE;
      chk_vld_q   <= 1'b0;
      out_valid_q <= 1'b0;
      for (int i = 0; i < CAPACITY; i++) begin
        used_q[i] <= 1'b0;
      end
    end else begin
      state_q     <= state_d;
      chk_vld_q   <= (state_q == BK_SCAN);
      out_valid_q <= out_valid_d;
      if (key_we) begin
        used_q[wr_idx] <= 1'b1;
      end
    end
  end

  // job and scan bookkeeping
  always_ff @(posedge clk_i) begin
    job_q        <= job_d;
    scan_q       <= scan_d;
    chk_idx_q    <= scan_q;
    rd_used_q    <= used_q[scan_q];
    hit_vld_q    <= hit_vld_d;
    hit_live_q   <= hit_live_d;
    hit_idx_q    <= hit_idx_d;
    room_vld_q   <= room_vld_d;
    room_idx_q   <= room_idx_d;
    cnt_q        <= cnt_d;
    out_count_q  <= out_count_d;
    out_status_q <= out_status_d;
  end

  // slot key and expiry memories, one write and one registered read
  always_ff @(posedge clk_i) begin
    if (key_we) begin
      key_mem[wr_idx] <= job_q.key;
    end
    if (exp_we) begin
      exp_mem[wr_idx] <= job_q.expiry;
    end
    if (state_q == BK_SCAN) begin
      rd_key_q <= key_mem[scan_q];
      rd_exp_q <= exp_mem[scan_q];
    end
  end

  // response word
  assign rsp.valid      = out_valid_q;
  assign rsp.live_count = out_count_q;
  assign rsp.status     = out_status_q;

endmodule

`default_nettype wire

// ===== hdl/token_expiry_table.sv =====
// ----------------------------------------------------------------------------
// token_expiry_table
// Lease table of token keys with expiry times: generate, renew and count.
// ----------------------------------------------------------------------------
// Usage:
//   req carries one request word (command, token_key, now) under valid/ready;
//   rsp returns exactly one response word (live_count, status) per request,
//   in order, under valid/ready. The APB port holds the lifetime register.
//   The front end takes a request whenever its two-entry job queue has room,
//   so up to two requests can be taken while the scan engine is busy.
//   Every generate, renew and count scans all CAPACITY slots one slot per
//   cycle through the key and expiry memories (single registered read port),
//   passing through the idle, scan, drain and done states; an unused command
//   goes from idle straight to done. The engine takes no new request word
//   until it has answered the last one and returned to idle.
//   Reset clears the slot valid bits, the queue and the lifetime register;
//   no clearing pass is needed. When rsp stalls, the result waits in the
//   output register, the engine holds its finished job and the queue fills,
//   after which req.ready drops.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module token_expiry_table import tet_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input  wire logic               clk_i,
  input  wire logic               rst_ni,
  tet_req_if.sink                 req,
  tet_rsp_if.source               rsp,
  input  wire logic               psel,
  input  wire logic               penable,
  input  wire logic               pwrite,
  input  wire logic [PADDR_W-1:0] paddr,
  input  wire logic [31:0]        pwdata,
  output      logic [31:0]        prdata,
  output      logic               pready
);

  job_t push_job, head_job;
  logic push, pop, q_full, q_empty;

  // accept and classify
  tet_front u_front (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .push_o  (push),
    .job_o   (push_job),
    .full_i  (q_full)
  );

  // decoupling queue
  tet_queue u_queue (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .job_i   (push_job),
    .full_o  (q_full),
    .pop_i   (pop),
    .job_o   (head_job),
    .empty_o (q_empty)
  );

  // scan and commit
  tet_back #(
    .CAPACITY (CAPACITY)
  ) u_back (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .job_i   (head_job),
    .empty_i (q_empty),
    .pop_o   (pop),
    .rsp     (rsp)
  );

endmodule

`default_nettype wire

// ===== hdl/tet_checker.sv =====
// ----------------------------------------------------------------------------
// tet_checker
// Port-level checks of the token expiry table, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "token_expiry_table_defines.svh"

module tet_checker import tet_pkg::*; #(
  parameter int unsigned CAPACITY = CAPACITY_DEFAULT
) (
  input wire logic              clk_i,
  input wire logic              rst_ni,
  input wire logic              req_valid_i,
  input wire logic              req_ready_i,
  input wire logic              rsp_valid_i,
  input wire logic              rsp_ready_i,
  input wire logic [LIVE_W-1:0] rsp_live_count_i,
  input wire logic [1:0]        rsp_status_i
);

  localparam logic [LIVE_W-1:0] MAX_LIVE = LIVE_W'((CAPACITY > 127) ? 127 : CAPACITY);

  logic [2:0] pend_q, pend_d;
  logic       in_acc, out_acc;
  logic       rsp_stall, rsp_fail;

  // words taken but not yet answered
  assign in_acc  = req_valid_i && req_ready_i;
  assign out_acc = rsp_valid_i && rsp_ready_i;

  // response offered but held off, and response reporting a failure
  assign rsp_stall = rsp_valid_i && !rsp_ready_i;
  assign rsp_fail  = rsp_valid_i && (rsp_status_i != ST_DONE);

  always_comb begin
    pend_d = pend_q;
    if (in_acc && !out_acc) begin
      pend_d = pend_q + 1'b1;
    end else if (!in_acc && out_acc) begin
      pend_d = pend_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pend_q <= '0;
    end else begin
      pend_q <= pend_d;
    end
  end

  // a stalled response stays offered
  `TET_ASSERT_NEXT(a_rsp_hold, rsp_stall, rsp_valid_i, "response dropped while stalled")

  // no response without a request that caused it
  `TET_ASSERT_NOW(a_rsp_caused, rsp_valid_i, pend_q != 3'd0, "response without request")

  // a failed request reports no count
  `TET_ASSERT_NOW(a_fail_no_count, rsp_fail, rsp_live_count_i == '0, "count on failed request")

  // the count never exceeds the table size
  `TET_ASSERT_NOW(a_count_cap, rsp_valid_i, rsp_live_count_i <= MAX_LIVE, "count above capacity")

endmodule

bind token_expiry_table tet_checker #(
  .CAPACITY (CAPACITY)
) u_tet_checker (
  .clk_i            (clk_i),
  .rst_ni           (rst_ni),
  .req_valid_i      (req.valid),
  .req_ready_i      (req.ready),
  .rsp_valid_i      (rsp.valid),
  .rsp_ready_i      (rsp.ready),
  .rsp_live_count_i (rsp.live_count),
  .rsp_status_i     (rsp.status)
);

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the token expiry table. A request-level predictor of
// the lease table tracks every accepted request word and queues the answer it
// implies; the response channel is compared field by field, in order. Traffic
// runs under several lifetime settings and four sender/receiver idle mixes.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module testbench;
  import tet_pkg::*;

  localparam int unsigned SLOTS       = CAPACITY_DEFAULT;
  localparam int unsigned CYCLE_LIMIT = 1000000;
  localparam int unsigned KEY_POOL    = 48;
  localparam int unsigned PRINT_CAP   = 40;
  localparam logic [1:0]  CMD_UNUSED  = 2'd3;
  localparam logic [PADDR_W-1:0] LIFETIME_ADDR = PADDR_W'(REG_LIFETIME) << 2;

  typedef struct packed {
    logic [LIVE_W-1:0] live_count;
    status_e           status;
  } lease_answer_t;

  logic        clk_i;
  logic        rst_ni;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [PADDR_W-1:0] paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  tet_req_if req_ch ();
  tet_rsp_if rsp_ch ();

  token_expiry_table uut (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .req     (req_ch),
    .rsp     (rsp_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // predicted lease table state
  logic              lease_used   [SLOTS];
  logic [KEY_W-1:0]  lease_key    [SLOTS];
  logic [EXP_W-1:0]  lease_expiry [SLOTS];
  logic [TIME_W-1:0] lease_lifetime;
  logic [TIME_W-1:0] lease_clock;

  lease_answer_t expected_answers[$];
  lease_answer_t oldest_answer;

  int mismatch_count;
  int cycle_count;
  int send_idle_pct;
  int recv_stall_pct;
  int n_generate, n_renew, n_count, n_unused;
  int n_full, n_absent, n_lifetimes, n_answers;

  // clock
  initial begin
    clk_i = 1'b0;
    forever #2 clk_i = ~clk_i;
  end

  // response side: random backpressure
  initial begin
    rsp_ch.ready = 1'b0;
    forever begin
      @(negedge clk_i);
      rsp_ch.ready = ($urandom_range(0, 99) >= recv_stall_pct);
    end
  end

  // run limit
  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("run limit of %0d cycles reached", CYCLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
    end
  end

  task automatic report_mismatch(input string what, input logic [63:0] got,
                                 input logic [63:0] want);
    mismatch_count++;
    if (mismatch_count <= PRINT_CAP)
      $display("[%0t] mismatch on %s: got %0d, want %0d", $time, what, got, want);
  endtask

  // lease table predictor: applies one request, returns its answer word
  function automatic lease_answer_t apply_lease_request(input logic [1:0] cmd,
                                                        input logic [KEY_W-1:0] key,
                                                        input logic [TIME_W-1:0] t);
    lease_answer_t ans;
    logic [EXP_W-1:0] t_wide;
    logic [EXP_W-1:0] renewed;
    int hit;
    int room;
    ans.live_count = '0;
    ans.status     = ST_DONE;
    t_wide  = {1'b0, t};
    renewed = t_wide + {1'b0, lease_lifetime};
    hit  = -1;
    room = -1;
    for (int i = 0; i < SLOTS; i++)
      if (hit < 0 && lease_used[i] && lease_key[i] == key) hit = i;
    case (cmd)
      CMD_GENERATE: begin
        // held key is overwritten, else lowest free or expired slot
        if (hit < 0)
          for (int i = 0; i < SLOTS; i++)
            if (room < 0 && (!lease_used[i] || lease_expiry[i] <= t_wide)) room = i;
        if (hit < 0) hit = room;
        if (hit < 0) begin
          ans.status = ST_FULL;
        end else begin
          lease_used[hit]   = 1'b1;
          lease_key[hit]    = key;
          lease_expiry[hit] = renewed;
        end
      end
      CMD_RENEW: begin
        if (hit >= 0 && lease_expiry[hit] > t_wide) lease_expiry[hit] = renewed;
        else ans.status = ST_ABSENT;
      end
      CMD_COUNT: begin
        for (int i = 0; i < SLOTS; i++)
          if (lease_used[i] && lease_expiry[i] > t_wide && ans.live_count < COUNT_MAX)
            ans.live_count++;
      end
      default: begin
        // unused command: no change
      end
    endcase
    return ans;
  endfunction

  // response check against the oldest predicted answer
  always @(posedge clk_i) begin
    if (rst_ni && rsp_ch.valid && rsp_ch.ready) begin
      n_answers++;
      if (expected_answers.size() == 0) begin
        report_mismatch("unexpected response word", rsp_ch.status, 0);
      end else begin
        oldest_answer = expected_answers.pop_front();
        if (rsp_ch.live_count !== oldest_answer.live_count)
          report_mismatch("live_count", rsp_ch.live_count, oldest_answer.live_count);
        if (rsp_ch.status !== oldest_answer.status)
          report_mismatch("status", rsp_ch.status, oldest_answer.status);
      end
    end
  end

  // one request word; prediction is made at acceptance
  task automatic send_request(input logic [1:0] cmd, input logic [KEY_W-1:0] key,
                              input logic [TIME_W-1:0] t);
    lease_answer_t ans;
    @(negedge clk_i);
    while ($urandom_range(0, 99) < send_idle_pct) begin
      req_ch.valid = 1'b0;
      @(negedge clk_i);
    end
    req_ch.valid     = 1'b1;
    req_ch.command   = cmd;
    req_ch.token_key = key;
    req_ch.now       = t;
    @(posedge clk_i);
    while (!req_ch.ready) @(posedge clk_i);
    ans = apply_lease_request(cmd, key, t);
    expected_answers = {expected_answers, ans};
    case (cmd)
      CMD_GENERATE: n_generate++;
      CMD_RENEW:    n_renew++;
      CMD_COUNT:    n_count++;
      default:      n_unused++;
    endcase
    if (ans.status == ST_FULL) n_full++;
    if (ans.status == ST_ABSENT) n_absent++;
  endtask

  // stop sending and wait for every outstanding answer
  task automatic drain_answers(input int settle);
    @(negedge clk_i);
    req_ch.valid = 1'b0;
    while (expected_answers.size() != 0) @(posedge clk_i);
    repeat (settle) @(posedge clk_i);
  endtask

  // one apb transfer: setup then access
  task automatic apb_transfer(input logic wr, input logic [31:0] wdata,
                              output logic [31:0] rdata);
    @(negedge clk_i);
    psel    = 1'b1;
    penable = 1'b0;
    pwrite  = wr;
    paddr   = LIFETIME_ADDR;
    pwdata  = wdata;
    @(negedge clk_i);
    penable = 1'b1;
    @(posedge clk_i);
    while (!pready) @(posedge clk_i);
    rdata = prdata;
    @(negedge clk_i);
    psel    = 1'b0;
    penable = 1'b0;
    pwrite  = 1'b0;
  endtask

  // lifetime write with readback; only called while the table is idle
  task automatic set_lifetime(input logic [31:0] value);
    logic [31:0] rd;
    apb_transfer(1'b1, value, rd);
    lease_lifetime = value;
    n_lifetimes++;
    apb_transfer(1'b0, '0, rd);
    if (rd !== value) report_mismatch("lifetime readback", rd, value);
  endtask

  // directed: all commands, key and time extremes, reuse, decreasing time
  task automatic test_directed();
    logic [31:0] rd;
    apb_transfer(1'b0, '0, rd);
    if (rd !== '0) report_mismatch("lifetime after reset", rd, 0);
    set_lifetime(32'd100);
    send_request(CMD_COUNT, 32'h0, 32'd0);
    send_request(CMD_GENERATE, 32'h0, 32'd0);
    send_request(CMD_GENERATE, 32'hFFFF_FFFF, 32'd0);
    send_request(CMD_COUNT, 32'hFFFF_FFFF, 32'd0);
    send_request(CMD_RENEW, 32'h0, 32'd50);
    send_request(CMD_RENEW, 32'h0001_2345, 32'd60);
    send_request(CMD_COUNT, 32'h0, 32'd99);
    // renew exactly at expiry fails
    send_request(CMD_RENEW, 32'hFFFF_FFFF, 32'd100);
    send_request(CMD_COUNT, 32'h0, 32'd100);
    // new key takes the expired slot, old key is then gone
    send_request(CMD_GENERATE, 32'h0000_0007, 32'd120);
    send_request(CMD_RENEW, 32'hFFFF_FFFF, 32'd120);
    send_request(CMD_UNUSED, 32'hA5A5_5A5A, 32'd120);
    send_request(CMD_GENERATE, 32'h0, 32'd130);
    // time going backwards
    send_request(CMD_COUNT, 32'h5A5A_A5A5, 32'd10);
    send_request(CMD_RENEW, 32'h0000_0007, 32'd0);
    // top of the time range, expiry needs the extra bit
    send_request(CMD_COUNT, 32'h0, 32'hFFFF_FFFF);
    send_request(CMD_GENERATE, 32'h0000_0005, 32'hFFFF_FFFF);
    send_request(CMD_COUNT, 32'h0, 32'hFFFF_FFFF);
    send_request(CMD_UNUSED, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
  endtask

  // random mix of commands over a pool of keys, time mostly advancing
  task automatic test_random_traffic(input int n_items, input logic [31:0] life);
    logic [KEY_W-1:0] key_pool [KEY_POOL];
    logic [KEY_W-1:0] key;
    logic [1:0] cmd;
    int pick;
    drain_answers(0);
    set_lifetime(life);
    foreach (key_pool[k]) key_pool[k] = $urandom();
    key_pool[0] = '0;
    key_pool[1] = '1;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(0, 99);
      if (pick < 40) cmd = CMD_GENERATE;
      else if (pick < 70) cmd = CMD_RENEW;
      else if (pick < 95) cmd = CMD_COUNT;
      else cmd = CMD_UNUSED;
      if ($urandom_range(0, 9) < 8) key = key_pool[$urandom_range(0, KEY_POOL - 1)];
      else key = $urandom();
      pick = $urandom_range(0, 99);
      if (pick < 2) lease_clock = lease_clock - $urandom_range(0, 50);
      else if (pick < 6) lease_clock = lease_clock + $urandom_range(100, 5000);
      else lease_clock = lease_clock + $urandom_range(0, 8);
      send_request(cmd, key, lease_clock);
    end
  endtask

  // fill every slot with live keys until generates are dropped
  task automatic test_table_full();
    logic [KEY_W-1:0] first_key;
    logic [TIME_W-1:0] t;
    drain_answers(0);
    set_lifetime(32'd5000);
    t = lease_clock;
    first_key = $urandom();
    send_request(CMD_GENERATE, first_key, t);
    for (int k = 0; k < SLOTS + 5; k++) send_request(CMD_GENERATE, $urandom(), t);
    send_request(CMD_COUNT, $urandom(), t);
    send_request(CMD_RENEW, first_key, t + 32'd10);
    send_request(CMD_GENERATE, first_key, t + 32'd20);
    // everything from the fill has now run out
    t = t + 32'd6000;
    send_request(CMD_COUNT, $urandom(), t);
    send_request(CMD_GENERATE, $urandom(), t);
    send_request(CMD_RENEW, first_key, t);
    lease_clock = t;
  endtask

  // zero and maximum lifetime
  task automatic test_lifetime_extremes();
    logic [KEY_W-1:0] key;
    drain_answers(0);
    set_lifetime(32'd0);
    key = $urandom();
    send_request(CMD_GENERATE, key, lease_clock);
    send_request(CMD_RENEW, key, lease_clock);
    send_request(CMD_COUNT, key, lease_clock);
    drain_answers(0);
    set_lifetime(32'hFFFF_FFFF);
    key = $urandom();
    send_request(CMD_GENERATE, key, 32'hFFFF_FFFF);
    send_request(CMD_RENEW, key, 32'hFFFF_FFFF);
    send_request(CMD_COUNT, key, 32'hFFFF_FFFF);
  endtask

  // test sequence
  initial begin
    int send_plan [4];
    int recv_plan [4];
    logic [31:0] life_plan [8];
    rst_ni           = 1'b0;
    psel             = 1'b0;
    penable          = 1'b0;
    pwrite           = 1'b0;
    paddr            = '0;
    pwdata           = '0;
    req_ch.valid     = 1'b0;
    req_ch.command   = CMD_GENERATE;
    req_ch.token_key = '0;
    req_ch.now       = '0;
    send_idle_pct    = 0;
    recv_stall_pct   = 0;
    lease_lifetime   = '0;
    foreach (lease_used[i]) lease_used[i] = 1'b0;
    send_plan = '{0, 55, 0, 12};
    recv_plan = '{0, 0, 55, 12};
    // long lifetimes last so their entries do not crowd out earlier phases
    life_plan = '{32'd37, 32'd0, 32'd150, 32'd1, 32'd600, 32'd4000,
                  $urandom(), 32'hFFFF_FFFF};
    lease_clock = $urandom_range(0, 32'h4000_0000);
    repeat (4) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni = 1'b1;

    test_directed();
    for (int p = 0; p < 4; p++) begin
      send_idle_pct  = send_plan[p];
      recv_stall_pct = recv_plan[p];
      test_random_traffic(105, life_plan[2 * p]);
      test_random_traffic(105, life_plan[2 * p + 1]);
      if (p == 1 || p == 3) test_table_full();
    end
    test_lifetime_extremes();
    drain_answers(SLOTS + 8);

    $display("covered %0d requests (%0d generate, %0d renew, %0d count, %0d unused), %0d answers",
             n_generate + n_renew + n_count + n_unused, n_generate, n_renew, n_count,
             n_unused, n_answers);
    $display("saw %0d full-table drops and %0d refused renews over %0d lifetime settings",
             n_full, n_absent, n_lifetimes);
    if (mismatch_count == 0) begin
      $display("SCOREBOARD CLEAN");
    end else begin
      $display("SCOREBOARD MISMATCH");
    end
    $finish;
  end

endmodule
